>>> hdl/cosim_pkg.sv
// Package for the cosine similarity block: widths, shared types and constants.
// No dependencies.
package cosim_pkg;
	localparam int ElemW = 16;
	localparam int AccW  = 48;
	localparam int RootW = 24;
	localparam int DenW  = 48;
	localparam int NumW  = 63;
	localparam int VectorLenMaxDefault = 512;

	// controller to datapath commands
	typedef struct packed {
		logic accum;     // add the accepted pair into the sums
		logic clear;     // clear sums
		logic capture;   // latch sums into the back stage
		logic sqrt_step; // one root iteration
		logic den_mul;   // form the denominator
		logic div_init;  // load the divider
		logic div_step;  // one quotient bit
		logic finish;    // form the result word
	} cosim_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic den_zero;
	} cosim_sts_t;
endpackage

>>> hdl/cosim_if.sv
// Valid/ready channel carrying one word of type T.
// Depends on nothing.
interface cosim_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hdl/cosine_similarity.sv
// Top level of the cosine similarity block; joins controller and datapath.
// Depends on cosim_pkg, cosim_if, cosim_ctrl, cosim_dp.
//
//  channel    dir  word fields
//  pairs      in   elem_a[15:0], elem_b[15:0], last
//  result     out  similarity[15:0], degenerate
//
// A pair that is not last is added into the sums. A last pair is followed by the
// root iterations, the multiply, the divider load, the divide steps (skipped when
// the denominator is zero) and the finish step; input is held off meanwhile and
// until the result word is taken. arst_n clears sums and controller.
module cosine_similarity (
	input  logic clk,
	input  logic arst_n,
	cosim_if.sink   pairs,
	cosim_if.source result
);
	import cosim_pkg::*;

	cosim_cmd_t cmd;
	cosim_sts_t sts;

	cosim_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(pairs.valid), .in_last(pairs.data.last), .in_ready(pairs.ready),
		.out_valid(result.valid), .out_ready(result.ready),
		.sts(sts), .cmd(cmd)
	);

	cosim_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.elem_a(pairs.data.elem_a), .elem_b(pairs.data.elem_b),
		.cmd(cmd), .sts(sts),
		.similarity(result.data.similarity), .degenerate(result.data.degenerate)
	);
endmodule

>>> hdl/cosim_ctrl.sv
// Sequencer for the cosine similarity block: accumulate, roots, multiply, divide.
// Depends on cosim_pkg.
module cosim_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_last,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  cosim_pkg::cosim_sts_t  sts,
	output cosim_pkg::cosim_cmd_t  cmd
);
	import cosim_pkg::*;

	localparam logic [2:0] ST_ACC  = 3'd0;
	localparam logic [2:0] ST_SQRT = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DINI = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	localparam int SqrtSteps = RootW;
	localparam int DivSteps  = NumW;

	logic [2:0] state_q;
	logic [5:0] cnt_q;
	logic       acc_fire;

	assign in_ready  = (state_q == ST_ACC);
	assign out_valid = (state_q == ST_OUT);
	assign acc_fire  = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.accum     = acc_fire;
		cmd.capture   = acc_fire && in_last;
		cmd.clear     = acc_fire && in_last;
		cmd.sqrt_step = (state_q == ST_SQRT);
		cmd.den_mul   = (state_q == ST_MUL);
		cmd.div_init  = (state_q == ST_DINI);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.finish    = (state_q == ST_FIN);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_ACC: begin
					if (acc_fire && in_last) begin
						state_q <= ST_SQRT;
						cnt_q   <= '0;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(SqrtSteps - 1)) state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_DINI;
				ST_DINI: begin
					cnt_q   <= '0;
					state_q <= sts.den_zero ? ST_FIN : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DivSteps - 1)) state_q <= ST_FIN;
				end
				ST_FIN: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_ready) state_q <= ST_ACC;
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ACC) |-> !in_ready) else $error("input taken while busy");
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_fire && in_last) |=> (state_q == ST_SQRT)) else $error("last did not start roots");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
`endif
endmodule

>>> hdl/cosim_dp.sv
// Datapath: saturating accumulators, bit-serial roots, multiplier, restoring divider.
// Depends on cosim_pkg.
module cosim_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [cosim_pkg::ElemW-1:0] elem_a,
	input  logic signed [cosim_pkg::ElemW-1:0] elem_b,
	input  cosim_pkg::cosim_cmd_t         cmd,
	output cosim_pkg::cosim_sts_t         sts,
	output logic signed [cosim_pkg::ElemW-1:0] similarity,
	output logic                          degenerate
);
	import cosim_pkg::*;

	localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
	localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

	logic signed [AccW-1:0] dot_q, na_q, nb_q;
	logic signed [AccW-1:0] dot_n, na_n, nb_n;
	logic signed [2*ElemW-1:0] pab, paa, pbb;

	function automatic logic signed [AccW-1:0] sat_add(logic signed [AccW-1:0] acc,
			logic signed [2*ElemW-1:0] p);
		logic signed [AccW:0] s;
		s = {acc[AccW-1], acc} + (AccW+1)'(p);
		if (s > (AccW+1)'(AccMax)) return AccMax;
		if (s < (AccW+1)'(AccMin)) return AccMin;
		return s[AccW-1:0];
	endfunction

	assign pab = elem_a * elem_b;
	assign paa = elem_a * elem_a;
	assign pbb = elem_b * elem_b;
	assign dot_n = sat_add(dot_q, pab);
	assign na_n  = sat_add(na_q, paa);
	assign nb_n  = sat_add(nb_q, pbb);

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0; na_q <= '0; nb_q <= '0;
		end else if (cmd.clear) begin
			dot_q <= '0; na_q <= '0; nb_q <= '0;
		end else if (cmd.accum) begin
			dot_q <= dot_n; na_q <= na_n; nb_q <= nb_n;
		end
	end

	// back stage: roots one bit per cycle (remainder/root method)
	logic [AccW-1:0] va_q, vb_q;     // remaining radicand bits, shifted out two at a time
	logic [RootW+1:0] rema_q, remb_q;
	logic [RootW-1:0] ra_q, rb_q;
	logic signed [AccW-1:0] dotc_q;
	logic [DenW-1:0] den_q;

	// returns {next root bit, next remainder}
	function automatic logic [RootW+2:0] rem_next(logic [RootW+1:0] rem, logic [1:0] b,
			logic [RootW-1:0] r);
		logic [RootW+3:0] t, tr;
		t  = {rem, b};
		tr = {2'b00, r, 2'b01};
		if (t >= tr) return {1'b1, (RootW+2)'(t - tr)};
		return {1'b0, (RootW+2)'(t)};
	endfunction

	logic bta, btb;
	logic [RootW+1:0] rema_n, remb_n;
	assign {bta, rema_n} = rem_next(rema_q, va_q[AccW-1:AccW-2], ra_q);
	assign {btb, remb_n} = rem_next(remb_q, vb_q[AccW-1:AccW-2], rb_q);

	// divider registers
	logic [NumW-1:0] quo_q;
	logic [DenW:0]   drem_q;
	logic [DenW:0]   dtry;
	logic            dneg_q;
	assign dtry = {drem_q[DenW-1:0], quo_q[NumW-1]} - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			va_q   <= na_n;
			vb_q   <= nb_n;
			rema_q <= '0;
			remb_q <= '0;
			ra_q   <= '0;
			rb_q   <= '0;
			dotc_q <= dot_n;
		end else if (cmd.sqrt_step) begin
			va_q   <= {va_q[AccW-3:0], 2'b00};
			vb_q   <= {vb_q[AccW-3:0], 2'b00};
			rema_q <= rema_n;
			remb_q <= remb_n;
			ra_q   <= {ra_q[RootW-2:0], bta};
			rb_q   <= {rb_q[RootW-2:0], btb};
		end
		if (cmd.den_mul) den_q <= ra_q * rb_q;
		if (cmd.div_init) begin
			dneg_q <= dotc_q[AccW-1];
			quo_q  <= {(dotc_q[AccW-1] ? (AccW)'(-dotc_q) : dotc_q), 15'd0};
			drem_q <= '0;
		end else if (cmd.div_step) begin
			if (!dtry[DenW]) begin
				drem_q <= dtry;
				quo_q  <= {quo_q[NumW-2:0], 1'b1};
			end else begin
				drem_q <= {drem_q[DenW-1:0], quo_q[NumW-1]};
				quo_q  <= {quo_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign sts.den_zero = (den_q == '0);

	// saturate and sign the quotient, or flag a zero denominator as degenerate
	logic signed [ElemW-1:0] sim_q;
	logic                    deg_q;
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (den_q == '0) begin
				sim_q <= '0;
				deg_q <= 1'b1;
			end else begin
				deg_q <= 1'b0;
				if (dneg_q)
					sim_q <= (quo_q >= NumW'(32768)) ? 16'sh8000 : ElemW'(-quo_q);
				else
					sim_q <= (quo_q > NumW'(32767)) ? 16'sh7fff : ElemW'(quo_q);
			end
		end
	end
	assign similarity = sim_q;
	assign degenerate = deg_q;

`ifndef ASSERT_OFF
	a_norm_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		!na_q[AccW-1] && !nb_q[AccW-1]) else $error("norm negative");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (dot_q == '0)) else $error("sum not cleared");
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.den_mul |-> (rema_q <= {1'b0, ra_q, 1'b0})) else $error("root remainder too big");
`endif
endmodule
